// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, constants and command codes of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int TAG_BITS_DEF      = 16;
  localparam int SEVERITY_BITS_DEF = 8;
  localparam int ARRIVAL_BITS      = 32;
  localparam int STATUS_BITS       = 3;
  localparam int COMMAND_BITS      = 2;

  typedef enum logic [COMMAND_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SPARE  = 2'd3
  } command_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    DP_NOP     = 4'd0,
    DP_CLEAR   = 4'd1,
    DP_INS     = 4'd2,  // latch new entry, place at end
    DP_RD_PAR  = 4'd3,  // read parent of cursor
    DP_UP_CMP  = 4'd4,  // compare cur with parent, swap or stop
    DP_SRV_RD0 = 4'd5,  // latch root, read last
    DP_SRV_TAK = 4'd6,  // capture root, move last to root
    DP_RD_L    = 4'd7,  // read left child
    DP_RD_R    = 4'd8,  // read right child
    DP_DN_CMP  = 4'd9,  // pick best child, swap or stop
    DP_WB      = 4'd10, // write held entry at cursor
    DP_RD_ROOT = 4'd11  // read root
  } dp_op_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic cur_root;   // cursor at root
    logic has_left;
    logic has_right;
    logic up_swap;    // cur beats parent
    logic dn_swap;    // a child beats cur
    logic one_left;   // entry count equals one
  } dp_status_t;

endpackage

// ===== src/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// heap storage, cursor, held entry and comparators
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF,
  parameter int SEVERITY_BITS = SEVERITY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_op_t                       op,
  input  logic [TAG_BITS-1:0]          in_tag,
  input  logic [SEVERITY_BITS-1:0]     in_sev,
  output dp_status_t                   st,
  output logic [TAG_BITS-1:0]          served_tag,
  output logic [SEVERITY_BITS-1:0]     served_sev,
  output logic [$clog2(CAPACITY+1)-1:0] count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int EW = TAG_BITS + SEVERITY_BITS + ARRIVAL_BITS;

  typedef struct packed {
    logic [SEVERITY_BITS-1:0] sev;
    logic [ARRIVAL_BITS-1:0]  arr;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  entry_t held, other, rdat, wdat;
  logic [CW-1:0] cur, cnt;
  logic [ARRIVAL_BITS-1:0] arrival;
  logic we;
  logic [AW-1:0] addr;

  function automatic logic beats(entry_t a, entry_t b);
    if (a.sev != b.sev) return a.sev > b.sev;
    return a.arr < b.arr;
  endfunction

  // child indexes, one bit wider than the cursor
  logic [CW:0] left_idx, right_idx;
  assign left_idx  = {cur, 1'b1};
  assign right_idx = left_idx + 1'b1;

  spq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdat), .rdata(rdat)
  );

  // ram port select
  always_comb begin
    we   = 1'b0;
    addr = cur[AW-1:0];
    wdat = held;
    unique case (op)
      DP_RD_PAR: addr = AW'((cur - 1'b1) >> 1);
      DP_UP_CMP: begin
        we = 1'b1;
        wdat = beats(held, rdat) ? rdat : held;
      end
      DP_RD_ROOT: addr = '0;
      DP_SRV_RD0: addr = AW'(cnt - 1'b1);
      DP_RD_L: addr = left_idx[AW-1:0];
      DP_RD_R: addr = right_idx[AW-1:0];
      DP_DN_CMP: begin
        we = 1'b1;
        wdat = beats(rdat, other) ? (beats(rdat, held) ? rdat : held)
                                  : (beats(other, held) ? other : held);
        if (!st.has_right) wdat = beats(other, held) ? other : held;
      end
      DP_WB: we = 1'b1;
      default: ;
    endcase
  end

  // compare outputs, valid in the compare cycles
  logic dn_best_right;
  assign dn_best_right = st.has_right && beats(rdat, other);

  always_comb begin
    st.empty     = (cnt == '0);
    st.full      = (cnt == CW'(CAPACITY)) || (arrival == '1);
    st.cur_root  = (cur == '0);
    st.has_left  = left_idx < {1'b0, cnt};
    st.has_right = right_idx < {1'b0, cnt};
    st.up_swap   = beats(held, rdat);
    st.dn_swap   = dn_best_right ? beats(rdat, held) : beats(other, held);
    st.one_left  = (cnt == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      arrival <= ARRIVAL_BITS'(1);
    end else begin
      case (op)
        DP_CLEAR: begin
          cnt     <= '0;
          arrival <= ARRIVAL_BITS'(1);
        end
        DP_INS: begin
          cnt     <= cnt + 1'b1;
          arrival <= arrival + 1'b1;
        end
        DP_SRV_TAK: begin
          cnt <= cnt - 1'b1;
          if (st.one_left) arrival <= ARRIVAL_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      DP_CLEAR: begin
        served_tag <= '0;
        served_sev <= '0;
      end
      DP_INS: begin
        held       <= '{sev: in_sev, arr: arrival, tag: in_tag};
        cur        <= cnt;
        served_tag <= '0;
        served_sev <= '0;
      end
      DP_UP_CMP: cur <= (cur - 1'b1) >> 1;
      DP_SRV_RD0: other <= rdat;   // root from the previous read
      DP_SRV_TAK: begin
        // other holds the root, rdat holds the last entry
        served_tag <= other.tag;
        served_sev <= other.sev;
        held       <= rdat;
        cur        <= '0;
      end
      DP_RD_R: other <= rdat;      // left child
      DP_DN_CMP: cur <= dn_best_right ? CW'(right_idx) : CW'(left_idx);
      default: ;
    endcase
  end

  assign count = cnt;

endmodule

// ===== src/spq_controller.sv =====
// ----------------------------------------------------------------------------
// spq_controller
// command sequencer and stream handshake
// ----------------------------------------------------------------------------
module spq_controller import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  command_t   cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output status_t    status,
  output dp_op_t     op,
  input  dp_status_t st
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RPAR  = 11'b00000000010,
    S_UCMP  = 11'b00000000100,
    S_SRD0  = 11'b00000001000,
    S_SRDL  = 11'b00000010000,
    S_STAK  = 11'b00000100000,
    S_RDL   = 11'b00001000000,
    S_RDR   = 11'b00010000000,
    S_DCMP  = 11'b00100000000,
    S_WB    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  status_t status_next;
  logic out_valid_q;

  assign in_ready  = (state == S_IDLE) && !out_valid_q;
  assign out_valid = out_valid_q;

  always_comb begin
    state_next  = state;
    status_next = status;
    op          = DP_NOP;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        unique case (cmd)
          CMD_INSERT: if (st.full) begin
            status_next = ST_FULL;
            state_next  = S_OUT;
          end else begin
            op = DP_INS;
            status_next = ST_INSERTED;
            state_next  = S_RPAR;
          end
          CMD_SERVE: if (st.empty) begin
            status_next = ST_EMPTY;
            state_next  = S_OUT;
          end else begin
            status_next = ST_SERVED;
            state_next  = S_SRD0;
          end
          default: begin
            op = DP_CLEAR;
            status_next = ST_CLEARED;
            state_next  = S_OUT;
          end
        endcase
      end
      S_RPAR: if (st.cur_root) begin
        op = DP_WB;
        state_next = S_OUT;
      end else begin
        op = DP_RD_PAR;
        state_next = S_UCMP;
      end
      S_UCMP: begin
        if (st.up_swap) begin
          op = DP_UP_CMP;
          state_next = S_RPAR;
        end else begin
          op = DP_WB;
          state_next = S_OUT;
        end
      end
      // read root first, then the last slot
      S_SRD0: begin
        op = DP_RD_ROOT;
        state_next = S_SRDL;
      end
      S_SRDL: begin
        op = DP_SRV_RD0;     // latch root into other, read last slot
        state_next = S_STAK;
      end
      S_STAK: begin
        op = DP_SRV_TAK;
        state_next = S_RDL;
      end
      S_RDL: if (!st.has_left) begin
        op = DP_WB;
        state_next = S_OUT;
      end else begin
        op = DP_RD_L;
        state_next = S_RDR;
      end
      S_RDR: begin
        op = DP_RD_R;
        state_next = S_DCMP;
      end
      S_DCMP: if (st.dn_swap) begin
        op = DP_DN_CMP;
        state_next = S_RDL;
      end else begin
        op = DP_WB;
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_q <= 1'b0;
      status      <= ST_INSERTED;
    end else begin
      state  <= state_next;
      status <= status_next;
      if (state == S_OUT) out_valid_q <= 1'b1;
      else if (out_ready) out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== src/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded stable max-priority queue on a binary heap in single-port ram
// ----------------------------------------------------------------------------
// each input word is a command: insert, serve or clear; each gives exactly
// one output word with status, served tag and severity, and occupancy.
// one word is handled at a time, and all steps share the one ram port: an
// insert reads a parent and compares per level climbed; a serve reads root
// and last slot, moves the last entry to the root, then reads both children
// and compares per level descended. the next word is taken once the
// previous result has been delivered. equal severities leave in arrival
// order; clear and draining the queue restart the arrival stamp at one
module stable_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF,
  parameter int SEVERITY_BITS = SEVERITY_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // command[1:0], tag, severity, zero fill
  input  logic [((COMMAND_BITS+TAG_BITS+SEVERITY_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status[2:0], served_tag, served_severity, occupancy, zero fill
  output logic [((STATUS_BITS+TAG_BITS+SEVERITY_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0]
               m_tdata
);

  localparam int CW = $clog2(CAPACITY+1);

  dp_op_t op;
  dp_status_t st;
  status_t status;
  logic [TAG_BITS-1:0] stag;
  logic [SEVERITY_BITS-1:0] ssev;
  logic [CW-1:0] count;
  command_t cmd;

  assign cmd = command_t'(s_tdata[COMMAND_BITS-1:0]);

  spq_controller u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .cmd,
    .out_valid(m_tvalid), .out_ready(m_tready), .status, .op, .st
  );

  spq_datapath #(
    .CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS), .SEVERITY_BITS(SEVERITY_BITS)
  ) u_dp (
    .clk, .rst, .op,
    .in_tag(s_tdata[COMMAND_BITS +: TAG_BITS]),
    .in_sev(s_tdata[COMMAND_BITS+TAG_BITS +: SEVERITY_BITS]),
    .st, .served_tag(stag), .served_sev(ssev), .count
  );

  // served fields read as zero unless this word served an entry
  assign m_tdata = $bits(m_tdata)'({count,
                    (status == ST_SERVED) ? ssev : SEVERITY_BITS'(0),
                    (status == ST_SERVED) ? stag : TAG_BITS'(0),
                    status});

endmodule

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// port level checks on the stable priority queue
// ----------------------------------------------------------------------------
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // result stays until taken
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

  // no new word while a result waits
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accept during pending result");

  // occupancy never exceeds capacity
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:27] <= 7'd64) else $error("occupancy overflow");

  // clear leaves an empty queue
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == 3'd4 |-> m_tdata[33:27] == 7'd0)
    else $error("clear not empty");

endmodule

bind stable_priority_queue spq_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stable priority queue
// ----------------------------------------------------------------------------
// words go in through a task that keeps its own model of the queue and
// stores the result it predicts. a checker compares every output word
// field by field with the oldest stored result. both sides idle and stall
// at random. directed tests go first, then well-formed random traffic.
module tb;
  import spq_pkg::*;

  localparam int CAP       = 64;
  localparam int LIMIT_CYC = 1000000;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  sev;
    logic [31:0] arrival;
  } entry_t;

  // lowest field last, matching the output word layout
  typedef struct packed {
    logic [6:0]  occ;
    logic [7:0]  sev;
    logic [15:0] tag;
    status_t     status;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  entry_t      held[$];
  logic [31:0] next_arrival = 32'd1;
  outcome_t    pending[$];
  int          errors = 0;
  int          served_cnt = 0;
  int          full_cnt = 0;
  int          sent_cnt = 0;
  int          cycles = 0;

  stable_priority_queue i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("timeout with %0d results outstanding", pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // works out what the queue returns for one word and updates the model
  function automatic outcome_t queue_predict(command_t cmd, logic [15:0] tag,
                                             logic [7:0] sev);
    outcome_t o;
    int best;
    o = '0;
    if (cmd == CMD_INSERT) begin
      if (held.size() >= CAP || next_arrival == 32'hFFFF_FFFF) begin
        o.status = ST_FULL;
      end else begin
        held.push_back({tag, sev, next_arrival});
        next_arrival = next_arrival + 32'd1;
        o.status = ST_INSERTED;
      end
    end else if (cmd == CMD_SERVE) begin
      if (held.size() == 0) begin
        o.status = ST_EMPTY;
      end else begin
        // highest severity, earliest arrival among equals
        best = 0;
        foreach (held[i])
          if (held[i].sev > held[best].sev ||
              (held[i].sev == held[best].sev && held[i].arrival < held[best].arrival))
            best = i;
        o.tag = held[best].tag;
        o.sev = held[best].sev;
        held.delete(best);
        if (held.size() == 0) next_arrival = 32'd1;
        o.status = ST_SERVED;
      end
    end else begin
      // clear, spare code decodes as clear
      held.delete();
      next_arrival = 32'd1;
      o.status = ST_CLEARED;
    end
    o.occ = 7'(held.size());
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sends one word, waits for it to be taken, then maybe idles
  task automatic send_word(command_t cmd, logic [15:0] tag, logic [7:0] sev,
                           bit idle_ok = 1);
    int gap;
    pending.push_back(queue_predict(cmd, tag, sev));
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, sev, tag, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_cnt++;
    gap = idle_ok ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0h, want %0h", field, got, want);
    errors++;
  endtask

  // output side: checks each word, stalls now and then
  int stall_left = 0;
  always @(posedge clk) begin
    outcome_t o;
    outcome_t w;
    if (!rst && m_tvalid && m_tready) begin
      o = m_tdata[33:0];
      if (m_tdata[39:34] != '0) report_mismatch("fill", m_tdata[39:34], 0);
      if (pending.size() == 0) begin
        $display("output word with nothing expected");
        errors++;
      end else begin
        w = pending.pop_front();
        if (o.status != w.status) report_mismatch("status", o.status, w.status);
        if (o.tag != w.tag) report_mismatch("served_tag", o.tag, w.tag);
        if (o.sev != w.sev) report_mismatch("served_severity", o.sev, w.sev);
        if (o.occ != w.occ) report_mismatch("occupancy", o.occ, w.occ);
        if (w.status == ST_SERVED) served_cnt++;
        if (w.status == ST_FULL) full_cnt++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 12)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
    end
  end

  task automatic wait_drained();
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(CMD_SERVE, 16'h1234, 8'h56);   // serve when empty
    send_word(CMD_INSERT, 16'h0000, 8'h00);
    send_word(CMD_INSERT, 16'hFFFF, 8'hFF);
    send_word(CMD_INSERT, 16'hAAAA, 8'h80, 0);
    send_word(CMD_INSERT, 16'h5555, 8'h80, 0); // equal severity keeps order
    send_word(CMD_INSERT, 16'h0F0F, 8'h80);
    send_word(CMD_SERVE, 16'hFFFF, 8'hFF);
    send_word(CMD_SERVE, 16'h0, 8'h0);
    send_word(CMD_SERVE, 16'h0, 8'h0);
    send_word(CMD_SPARE, 16'hFFFF, 8'hFF);   // spare code acts as clear
    send_word(CMD_SERVE, 16'h0, 8'h0);
    send_word(CMD_INSERT, 16'h0001, 8'h01);
    send_word(CMD_SERVE, 16'h0, 8'h0);       // drains, stamp restarts
    send_word(CMD_INSERT, 16'h0002, 8'h01);
    send_word(CMD_INSERT, 16'h0003, 8'h01);
    send_word(CMD_CLEAR, 16'hFFFF, 8'hFF);
    send_word(CMD_SERVE, 16'h0, 8'h0);
  endtask

  // fill to capacity with few severities, refuse one, drain in order
  task automatic test_full_drain();
    for (int i = 0; i < CAP; i++)
      send_word(CMD_INSERT, 16'(i), 8'($urandom_range(0, 3)));
    send_word(CMD_INSERT, 16'hBEEF, 8'hFF);
    for (int i = 0; i < CAP + 1; i++)
      send_word(CMD_SERVE, 16'($urandom), 8'($urandom));
  endtask

  task automatic test_random(int n);
    int r;
    int ins_bias;
    command_t c;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) ins_bias = $urandom_range(30, 80);
      r = $urandom_range(0, 99);
      if (r < 2) c = ($urandom_range(0, 1) != 0) ? CMD_CLEAR : CMD_SPARE;
      else if ($urandom_range(0, 99) < ins_bias) c = CMD_INSERT;
      else c = CMD_SERVE;
      // narrow severities now and then to stress the tie break
      send_word(c, 16'($urandom),
                ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_drain();
    test_random(1520);
    test_full_drain();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    $display("sent %0d words, %0d served, %0d refused as full",
             sent_cnt, served_cnt, full_cnt);
    $display("covered empty serve, full insert, ties, clear, spare code, drain restart");
    if (errors == 0 && pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
